/* sv/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and encode helpers for the utf-16 to utf-8 encoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_W     = 32;
    localparam int CW_EXT      = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam int MAX_BYTES   = 6;
    localparam int IDX_W       = $clog2(MAX_BYTES);

    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
    localparam logic [20:0] PLANE_BASE    = 21'h10000;
    localparam logic [15:0] ONE_BYTE_LIM  = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIM  = 16'h0800;
    localparam logic [7:0]  LEAD4         = 8'hF0;
    localparam logic [7:0]  LEAD3         = 8'hE0;
    localparam logic [7:0]  LEAD2         = 8'hC0;
    localparam logic [7:0]  CONT          = 8'h80;
    localparam logic [7:0]  CONT_MASK     = 8'h3F;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } unit_enc_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          count;
        logic                      last;
        logic [TOTAL_W-1:0]        total;
    } job_t;

    function automatic unit_enc_t encode_unit(logic [15:0] u);
        unit_enc_t r;
        r = '0;
        if (u < ONE_BYTE_LIM)
        begin
            r.bytes[0] = {1'b0, u[6:0]};
            r.count    = 2'd1;
        end
        else if (u < TWO_BYTE_LIM)
        begin
            r.bytes[0] = LEAD2 | {3'b000, u[10:6]};
            r.bytes[1] = CONT | (CONT_MASK & {2'b00, u[5:0]});
            r.count    = 2'd2;
        end
        else
        begin
            r.bytes[0] = LEAD3 | {4'h0, u[15:12]};
            r.bytes[1] = CONT | (CONT_MASK & {2'b00, u[11:6]});
            r.bytes[2] = CONT | (CONT_MASK & {2'b00, u[5:0]});
            r.count    = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] clip_total(logic [COUNT_WIDTH-1:0] v);
        logic [CW_EXT-1:0] ext;
        ext = CW_EXT'(v);
        if (ext > CW_EXT'({TOTAL_W{1'b1}}))
            return {TOTAL_W{1'b1}};
        else
            return ext[TOTAL_W-1:0];
    endfunction

endpackage

/* sv/u16u8_enc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_enc
// surrogate pairing, byte assembly and length count, one code unit per cycle while in_stall is low
// ----------------------------------------------------------------------------
module u16u8_enc
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        string_last,
    output job_t        job,
    output logic        job_valid,
    input  logic        job_take
);

    logic                   held_valid_reg, held_valid_next;
    logic [15:0]            held_high_reg, held_high_next;
    logic [COUNT_WIDTH-1:0] byte_total_reg, byte_total_next;
    logic                   job_valid_reg, job_valid_next;
    job_t                   job_reg, job_next;

    logic                   accept;
    logic                   is_high, is_low, hold_new;
    unit_enc_t              unit_enc, held_enc;
    logic [20:0]            cp;
    logic [COUNT_WIDTH:0]   sum_ext;
    logic [COUNT_WIDTH-1:0] sum_sat;

    assign in_stall  = job_valid_reg && !job_take;
    assign accept    = in_valid && !in_stall;
    assign job       = job_reg;
    assign job_valid = job_valid_reg;

    assign is_high  = (code_unit >= SURR_HIGH_MIN) && (code_unit <= SURR_HIGH_MAX);
    assign is_low   = (code_unit >= SURR_LOW_MIN) && (code_unit <= SURR_LOW_MAX);
    assign hold_new = is_high && !string_last;
    assign unit_enc = encode_unit(code_unit);
    assign held_enc = encode_unit(held_high_reg);
    assign cp       = PLANE_BASE + {1'b0, held_high_reg[9:0], code_unit[9:0]};

    always_comb
    begin
        job_next        = '0;
        held_valid_next = 1'b0;
        held_high_next  = '0;
        if (held_valid_reg && is_low)
        begin
            job_next.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            job_next.bytes[1] = CONT | (CONT_MASK & {2'b00, cp[17:12]});
            job_next.bytes[2] = CONT | (CONT_MASK & {2'b00, cp[11:6]});
            job_next.bytes[3] = CONT | (CONT_MASK & {2'b00, cp[5:0]});
            job_next.count    = IDX_W'(4);
        end
        else if (held_valid_reg)
        begin
            job_next.bytes[2:0] = held_enc.bytes;
            if (hold_new)
            begin
                job_next.count  = IDX_W'(3);
                held_valid_next = 1'b1;
                held_high_next  = code_unit;
            end
            else
            begin
                job_next.bytes[5:3] = unit_enc.bytes;
                job_next.count      = IDX_W'(3) + IDX_W'(unit_enc.count);
            end
        end
        else
        begin
            if (hold_new)
            begin
                held_valid_next = 1'b1;
                held_high_next  = code_unit;
            end
            else
            begin
                job_next.bytes[2:0] = unit_enc.bytes;
                job_next.count      = IDX_W'(unit_enc.count);
            end
        end
        job_next.last = string_last;

        sum_ext = (COUNT_WIDTH+1)'(byte_total_reg) + (COUNT_WIDTH+1)'(job_next.count);
        if (sum_ext[COUNT_WIDTH])
            sum_sat = {COUNT_WIDTH{1'b1}};
        else
            sum_sat = sum_ext[COUNT_WIDTH-1:0];
        job_next.total  = string_last ? clip_total(sum_sat) : '0;
        byte_total_next = string_last ? '0 : sum_sat;

        job_valid_next = job_valid_reg && !job_take;
        if (accept)
            job_valid_next = (job_next.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
            byte_total_reg <= '0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            if (accept)
            begin
                held_valid_reg <= held_valid_next;
                held_high_reg  <= held_high_next;
                byte_total_reg <= byte_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

`ifndef SYNTHESIS
    a_no_hold_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && string_last) |=> (!held_valid_reg && byte_total_reg == '0))
        else $error("surrogate or count carried across string end");
    a_hold_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !held_valid_reg && hold_new) |=> !job_valid_reg)
        else $error("job issued for a held surrogate");
    a_held_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (held_high_reg >= SURR_HIGH_MIN && held_high_reg <= SURR_HIGH_MAX))
        else $error("held unit is not a high surrogate");
`endif

endmodule

/* sv/u16u8_ser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_ser
// walks the bytes of one job into the output register, one byte per cycle while out_stall is low
// ----------------------------------------------------------------------------
module u16u8_ser
    import u16u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               job,
    input  logic               job_valid,
    output logic               job_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_end,
    output logic [TOTAL_W-1:0] total_bytes
);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               run_last_reg;
    logic               string_end_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               load, emit, final_byte;

    assign load       = !out_valid_reg || !out_stall;
    assign emit       = job_valid && load;
    assign final_byte = (idx_reg == job.count - IDX_W'(1));
    assign job_take   = emit && final_byte;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !load;
        if (emit)
        begin
            idx_next       = final_byte ? '0 : idx_reg + IDX_W'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= job.bytes[idx_reg];
            run_last_reg   <= final_byte;
            string_end_reg <= final_byte && job.last;
            total_reg      <= (final_byte && job.last) ? job.total : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_end  = string_end_reg;
    assign total_bytes = total_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (job.count != '0 && idx_reg < job.count))
        else $error("byte index outside job");
    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && string_end_reg) |-> run_last_reg)
        else $error("string end not on last byte of run");
    a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !string_end_reg) |-> (total_reg == '0))
        else $error("total reported before string end");
`endif

endmodule

/* sv/utf16_to_utf8_encoder.sv */
`timescale 1ns / 1ps
// the first utf-8 byte of a code unit goes through the encoder job register, then the serializer output register
// throughput: one output byte per cycle while out_stall is low; the input stalls until a job's last byte is taken
// a unit that is held as a high surrogate gives no bytes when it is accepted
// the single byte output register is the limit: a job holds at most 6 bytes, an ascii unit alone gives 1
// reset: rst_n async active low clears held surrogate, byte count and all valid flags
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// utf-16 code unit stream to utf-8 byte stream with running string length
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
    import u16u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        code_unit,
    input  logic               string_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_end,
    output logic [TOTAL_W-1:0] total_bytes
);

    job_t job;
    logic job_valid;
    logic job_take;

    u16u8_enc u_enc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .string_last (string_last),
        .job         (job),
        .job_valid   (job_valid),
        .job_take    (job_take)
    );

    u16u8_ser u_ser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_end  (string_end),
        .total_bytes (total_bytes)
    );

endmodule
